// ===== rtl/tsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsbc_pkg
// shared constants, types and diffusion matrices for the table s-box cipher
// ----------------------------------------------------------------------------
package tsbc_pkg;

    localparam int LanesDefault = 8;
    localparam int MaxLanes     = 16;
    localparam int LaneW        = 16;
    localparam int WordW        = 64;
    localparam int RoundW       = 6;
    localparam int FuncW        = 2;
    localparam int LaneIdxW     = 4;
    localparam logic [RoundW-1:0] RoundReset = 6'd8;

    typedef enum logic [FuncW-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_ENCRYPT = 2'd1,
        FUNC_DECRYPT = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef logic [LaneW-1:0] t_lane_val;

    // control from the sequencer to the lanes
    typedef struct packed {
        logic                load;
        logic                rd;
        logic                inv;
        logic [LaneIdxW-1:0] lane;
        logic [LaneW-1:0]    addr;
        logic [LaneW-1:0]    value;
    } t_lane_ctl;

    function automatic int eff_lanes(input int n);
        return (n >= 16) ? 16 : ((n >= 12) ? 12 : 8);
    endfunction

    function automatic logic [MaxLanes-1:0] mix_row(input int n, input int i);
        logic [MaxLanes-1:0] m8 [8];
        logic [MaxLanes-1:0] m12 [12];
        logic [MaxLanes-1:0] m16 [16];
        m8  = '{16'h9E, 16'hB3, 16'h67, 16'hCF, 16'hEC, 16'h35, 16'h7B, 16'hF6};
        m12 = '{16'h7E1, 16'hE72, 16'h57C, 16'hECC, 16'h3D6, 16'hAA7,
                16'h85F, 16'hCB9, 16'hF15, 16'h33B, 16'h58F, 16'h9EA};
        m16 = '{16'hFFFE, 16'hCCC1, 16'hAAA1, 16'h9991, 16'h6689, 16'h5585,
                16'h3383, 16'h007F, 16'hE069, 16'hD055, 16'hB033, 16'h700F,
                16'h0E69, 16'h0D55, 16'h0B33, 16'h070F};
        if (n == 16) begin
            return m16[i];
        end else if (n == 12) begin
            return m12[i % 12];
        end
        return m8[i % 8];
    endfunction

endpackage

// ===== rtl/table_sbox_block_cipher.sv =====
// ----------------------------------------------------------------------------
// table_sbox_block_cipher
// lane-parallel substitution/diffusion cipher with loadable s-box tables
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// config   | i_cfg_we           | i_cfg_data (round_count)
// command  | i_start / o_busy   | i_func, i_lane, i_table_addr, i_table_value, i_block_w*
// result   | o_done strobe      | o_result_w0..o_result_w3
// a load or ignored command leaves busy low.
// each round is an s-box memory read plus a diffusion, all lanes at once.
// done marks the end of the last round of either function; busy holds through the done cycle.
// synchronous active-low reset returns round_count to 8 and idles the sequencer;
// table contents are not cleared. done shows for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module table_sbox_block_cipher #(
    parameter int LANES = tsbc_pkg::LanesDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsbc_pkg::RoundW-1:0]   i_cfg_data,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tsbc_pkg::FuncW-1:0]    i_func,
    input  logic [tsbc_pkg::LaneIdxW-1:0] i_lane,
    input  logic [tsbc_pkg::LaneW-1:0]    i_table_addr,
    input  logic [tsbc_pkg::LaneW-1:0]    i_table_value,
    input  logic [tsbc_pkg::WordW-1:0]    i_block_w0,
    input  logic [tsbc_pkg::WordW-1:0]    i_block_w1,
    input  logic [tsbc_pkg::WordW-1:0]    i_block_w2,
    input  logic [tsbc_pkg::WordW-1:0]    i_block_w3,
    output logic                          o_done,
    output logic [tsbc_pkg::WordW-1:0]    o_result_w0,
    output logic [tsbc_pkg::WordW-1:0]    o_result_w1,
    output logic [tsbc_pkg::WordW-1:0]    o_result_w2,
    output logic [tsbc_pkg::WordW-1:0]    o_result_w3
);

    localparam int N = tsbc_pkg::eff_lanes(LANES);

    typedef enum logic [1:0] {S_IDLE, S_SUB, S_MIX} t_state;

    t_state                      r_state;
    logic [tsbc_pkg::RoundW-1:0] r_rounds;
    logic [tsbc_pkg::RoundW-1:0] r_left;
    logic                        r_inv;
    logic                        r_landed;
    logic                        r_done;
    tsbc_pkg::t_lane_val         r_v [N];
    tsbc_pkg::t_lane_val         sub_v [N];
    tsbc_pkg::t_lane_val         mix_in [N];
    tsbc_pkg::t_lane_val         mix_v [N];
    tsbc_pkg::t_lane_ctl         lane_ctl;
    logic [4*tsbc_pkg::WordW-1:0] blk_in;
    logic [4*tsbc_pkg::WordW-1:0] blk_out;
    logic                        accept;
    logic                        cipher;

    assign accept = i_start && !o_busy;
    assign cipher = (i_func == tsbc_pkg::FUNC_ENCRYPT) || (i_func == tsbc_pkg::FUNC_DECRYPT);
    assign blk_in = {i_block_w3, i_block_w2, i_block_w1, i_block_w0};

    // sub step reads memories; encrypt mixes after sub, decrypt mixes first
    assign lane_ctl.load  = accept && (i_func == tsbc_pkg::FUNC_LOAD);
    assign lane_ctl.rd    = (r_state == S_SUB);
    assign lane_ctl.inv   = r_inv;
    assign lane_ctl.lane  = i_lane;
    assign lane_ctl.addr  = i_table_addr;
    assign lane_ctl.value = i_table_value;

    for (genvar g = 0; g < N; g++) begin : g_lane
        tsbc_lane #(.LaneId(g)) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_din  (r_v[g]),
            .o_dout (sub_v[g])
        );
        assign mix_in[g] = r_landed ? sub_v[g] : r_v[g];
    end

    tsbc_mix #(.Lanes(LANES)) u_mix (
        .i_v (mix_in),
        .o_v (mix_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rounds <= tsbc_pkg::RoundReset;
            r_done   <= 1'b0;
            r_left   <= '0;
            r_inv    <= 1'b0;
            r_landed <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_rounds <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && cipher) begin
                        r_inv    <= (i_func == tsbc_pkg::FUNC_DECRYPT);
                        r_left   <= r_rounds;
                        r_landed <= 1'b0;
                        for (int i = 0; i < N; i++) begin
                            r_v[i] <= blk_in[16*i +: 16];
                        end
                        if (r_rounds == '0) begin
                            r_state <= S_MIX;
                        end else if (i_func == tsbc_pkg::FUNC_DECRYPT) begin
                            r_state <= S_MIX;
                        end else begin
                            r_state <= S_SUB;
                        end
                    end
                end
                S_SUB: begin
                    r_landed <= 1'b1;
                    r_state  <= S_MIX;
                end
                S_MIX: begin
                    if (r_left == '0) begin
                        // decrypt: last inverse read lands as the result
                        if (r_landed) begin
                            for (int i = 0; i < N; i++) begin
                                r_v[i] <= sub_v[i];
                            end
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_inv) begin
                        // decrypt: mix, then read inverse boxes
                        for (int i = 0; i < N; i++) begin
                            r_v[i] <= mix_v[i];
                        end
                        r_state <= S_SUB;
                        r_left  <= r_left - 1'b1;
                    end else begin
                        // encrypt: s-box output just arrived, mix it in
                        for (int i = 0; i < N; i++) begin
                            r_v[i] <= mix_v[i];
                        end
                        r_left <= r_left - 1'b1;
                        if (r_left == 6'd1) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SUB;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // pack lanes, unused words stay zero
    always_comb begin
        blk_out = '0;
        for (int i = 0; i < N; i++) begin
            blk_out[16*i +: 16] = r_v[i];
        end
    end

    assign o_busy      = (r_state != S_IDLE) || r_done;
    assign o_done      = r_done;
    assign o_result_w0 = blk_out[63:0];
    assign o_result_w1 = blk_out[127:64];
    assign o_result_w2 = blk_out[191:128];
    assign o_result_w3 = blk_out[255:192];

endmodule

// ===== rtl/tsbc_lane.sv =====
// ----------------------------------------------------------------------------
// tsbc_lane
// one lane: forward and inverse s-box memories with registered read
// ----------------------------------------------------------------------------
module tsbc_lane #(
    parameter int LaneId = 0
) (
    input  logic                 i_clk,
    input  tsbc_pkg::t_lane_ctl  i_ctl,
    input  tsbc_pkg::t_lane_val  i_din,
    output tsbc_pkg::t_lane_val  o_dout
);

    localparam int Depth = 1 << tsbc_pkg::LaneW;

    logic [tsbc_pkg::LaneW-1:0] fwd_mem [Depth];
    logic [tsbc_pkg::LaneW-1:0] inv_mem [Depth];
    tsbc_pkg::t_lane_val        r_fwd_q;
    tsbc_pkg::t_lane_val        r_inv_q;
    logic                       r_inv_sel;
    logic                       wr_en;

    assign wr_en = i_ctl.load && (i_ctl.lane == tsbc_pkg::LaneIdxW'(LaneId));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            fwd_mem[i_ctl.addr] <= i_ctl.value;
        end
        if (i_ctl.rd) begin
            r_fwd_q <= fwd_mem[i_din];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            inv_mem[i_ctl.value] <= i_ctl.addr;
        end
        if (i_ctl.rd) begin
            r_inv_q   <= inv_mem[i_din];
            r_inv_sel <= i_ctl.inv;
        end
    end

    assign o_dout = r_inv_sel ? r_inv_q : r_fwd_q;

endmodule

// ===== rtl/tsbc_mix.sv =====
// ----------------------------------------------------------------------------
// tsbc_mix
// xor diffusion matrix merging all lanes
// ----------------------------------------------------------------------------
module tsbc_mix #(
    parameter int Lanes = tsbc_pkg::LanesDefault
) (
    input  tsbc_pkg::t_lane_val i_v [tsbc_pkg::eff_lanes(Lanes)],
    output tsbc_pkg::t_lane_val o_v [tsbc_pkg::eff_lanes(Lanes)]
);

    localparam int N = tsbc_pkg::eff_lanes(Lanes);

    always_comb begin
        logic [tsbc_pkg::MaxLanes-1:0] row;
        for (int i = 0; i < N; i++) begin
            o_v[i] = '0;
            row    = tsbc_pkg::mix_row(N, i);
            for (int j = 0; j < N; j++) begin
                if (row[j]) begin
                    o_v[i] = o_v[i] ^ i_v[j];
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for table_sbox_block_cipher with 8 lanes. Each phase
// loads every lane's s-box with a permutation of a 4-bit XOR subspace. That
// subspace moves by 4 bits from one phase to the next. It then sends random
// encrypt, decrypt, load and ignored commands against a bench-side cipher
// model. Round counts of 8, 0, 63 and a small random value are covered.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Lanes = 8;
    localparam int NLane = (Lanes >= 16) ? 16 : ((Lanes >= 12) ? 12 : 8);
    localparam int SettleCycles = 140;

    typedef struct {
        tsbc_pkg::t_func func;
        logic [3:0]      lane;
        logic [15:0]     addr;
        logic [15:0]     value;
        logic [63:0]     w [4];
        int              gap_pct;
    } t_cmd;

    typedef struct {
        logic [63:0] w [4];
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tsbc_pkg::RoundW-1:0] i_cfg_data = '0;
    logic i_start = 1'b0;
    logic o_busy;
    logic [tsbc_pkg::FuncW-1:0] i_func = '0;
    logic [3:0] i_lane = '0;
    logic [15:0] i_table_addr = '0, i_table_value = '0;
    logic [63:0] i_block_w0 = '0, i_block_w1 = '0, i_block_w2 = '0, i_block_w3 = '0;
    logic o_done;
    logic [63:0] o_result_w0, o_result_w1, o_result_w2, o_result_w3;

    table_sbox_block_cipher #(.LANES(Lanes)) dut (.*);

    always #6 i_clk = ~i_clk;

    t_cmd   pending_cmds [$];
    t_block expected_blocks [$];
    logic [15:0] fwd_box [int];
    logic [15:0] inv_box [int];
    logic [tsbc_pkg::RoundW-1:0] rounds = tsbc_pkg::RoundReset;
    int n_issued = 0, n_taken = 0, n_queued = 0, n_errors = 0;
    t_cmd cur;

    const logic [15:0] mix8 [8] = '{16'h9E, 16'hB3, 16'h67, 16'hCF,
                                    16'hEC, 16'h35, 16'h7B, 16'hF6};

    function automatic void diffuse(ref logic [15:0] v [16]);
        logic [15:0] t [16];
        for (int i = 0; i < NLane; i++) begin
            t[i] = '0;
            for (int j = 0; j < NLane; j++)
                if (mix8[i][j]) t[i] ^= v[j];
        end
        for (int i = 0; i < NLane; i++) v[i] = t[i];
    endfunction

    // cipher model, also applies table loads
    function automatic void cipher_step(input t_cmd c);
        logic [15:0] v [16];
        t_block b;
        if (c.func == tsbc_pkg::FUNC_LOAD) begin
            if (c.lane < NLane) begin
                fwd_box[{c.lane, c.addr}] = c.value;
                inv_box[{c.lane, c.value}] = c.addr;
            end
            return;
        end
        if (c.func == tsbc_pkg::FUNC_NONE) return;
        for (int i = 0; i < 16; i++)
            v[i] = (i < NLane) ? c.w[i >> 2][16*(i & 3) +: 16] : '0;
        for (int r = 0; r < rounds; r++) begin
            if (c.func == tsbc_pkg::FUNC_ENCRYPT) begin
                for (int i = 0; i < NLane; i++) v[i] = fwd_box[{i[3:0], v[i]}];
                diffuse(v);
            end else begin
                diffuse(v);
                for (int i = 0; i < NLane; i++) v[i] = inv_box[{i[3:0], v[i]}];
            end
        end
        for (int k = 0; k < 4; k++) b.w[k] = '0;
        for (int i = 0; i < NLane; i++) b.w[i >> 2][16*(i & 3) +: 16] = v[i];
        expected_blocks.push_back(b);
    endfunction

    // driver
    always @(negedge i_clk) begin
        logic go;
        go = i_start;
        if (i_rst_n && (!i_start || n_taken == n_issued)) begin
            go = 1'b0;
            if (pending_cmds.size() > 0 &&
                    $urandom_range(99) >= pending_cmds[0].gap_pct) begin
                cur = pending_cmds.pop_front();
                n_issued++;
                go = 1'b1;
                i_func <= cur.func;
                i_lane <= cur.lane;
                i_table_addr <= cur.addr;
                i_table_value <= cur.value;
                i_block_w0 <= cur.w[0];
                i_block_w1 <= cur.w[1];
                i_block_w2 <= cur.w[2];
                i_block_w3 <= cur.w[3];
            end
        end
        i_start <= go;
    end

    // monitor
    always @(posedge i_clk) begin
        t_block b;
        logic [63:0] got [4];
        if (i_rst_n && i_start && !o_busy) begin
            n_taken <= n_taken + 1;
            cipher_step(cur);
        end
        if (i_rst_n && o_done) begin
            got = '{o_result_w0, o_result_w1, o_result_w2, o_result_w3};
            if (expected_blocks.size() == 0) begin
                $error("unexpected result transaction");
                n_errors++;
            end else begin
                b = expected_blocks.pop_front();
                for (int k = 0; k < 4; k++)
                    if (got[k] !== b.w[k]) begin
                        $error("result_w%0d expected %h actual %h", k, b.w[k], got[k]);
                        n_errors++;
                    end
            end
        end
    end

    function automatic int gap_for_next();
        return (n_queued < 267) ? 6 : ((n_queued < 534) ? 74 : 0);
    endfunction

    function automatic void queue_cmd(tsbc_pkg::t_func f, logic [3:0] ln, logic [15:0] a,
                                      logic [15:0] d, logic [63:0] w0,
                                      logic [63:0] w1, logic [63:0] w2,
                                      logic [63:0] w3);
        t_cmd c;
        c.func = f; c.lane = ln; c.addr = a; c.value = d;
        c.w = '{w0, w1, w2, w3};
        c.gap_pct = gap_for_next();
        pending_cmds.push_back(c);
        n_queued++;
    endfunction

    function automatic logic [63:0] rand_word64();
        return {$urandom, $urandom};
    endfunction

    // block word whose lanes all lie in the subspace at bit offset sh
    function automatic logic [63:0] subspace_word(int sh);
        logic [63:0] w;
        for (int j = 0; j < 4; j++) w[16*j +: 16] = 16'($urandom_range(15)) << sh;
        return w;
    endfunction

    function automatic logic [15:0] outside_value(int sh);
        logic [15:0] x;
        x = 16'($urandom);
        if ((x & ~(16'hF << sh)) == 0) x[(sh + 4) % 16] = 1'b1;
        return x;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || n_taken != n_issued || i_start ||
               expected_blocks.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_rounds(logic [tsbc_pkg::RoundW-1:0] r);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= r;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rounds = r;
    endtask

    initial begin
        logic [15:0] perm [16];
        logic [15:0] tmp;
        int sh, k, sel;
        logic [tsbc_pkg::RoundW-1:0] phase_rounds [4];
        phase_rounds = '{tsbc_pkg::RoundReset, 6'd0, 6'd63, 6'($urandom_range(1, 6))};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            sh = 4 * p;
            if (p > 0) begin
                wait_idle();
                write_rounds(phase_rounds[p]);
            end
            for (int ln = 0; ln < NLane; ln++) begin
                for (int i = 0; i < 16; i++) perm[i] = 16'(i) << sh;
                for (int i = 15; i > 0; i--) begin
                    k = $urandom_range(i);
                    tmp = perm[i]; perm[i] = perm[k]; perm[k] = tmp;
                end
                for (int i = 0; i < 16; i++)
                    queue_cmd(tsbc_pkg::FUNC_LOAD, ln[3:0], 16'(i) << sh, perm[i],
                              '0, '0, '0, '0);
            end
            if (p == 0) begin
                queue_cmd(tsbc_pkg::FUNC_ENCRYPT, 4'hF, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0);
                queue_cmd(tsbc_pkg::FUNC_DECRYPT, 4'h0, '0, '0, '0, '0, '1, '1);
                queue_cmd(tsbc_pkg::FUNC_ENCRYPT, '0, '0, '0, {4{16'hF}}, {4{16'hF}},
                          '1, '1);
                queue_cmd(tsbc_pkg::FUNC_DECRYPT, '0, '0, '0, {4{16'hF}}, {4{16'hF}},
                          '1, '1);
                queue_cmd(tsbc_pkg::FUNC_NONE, 4'hF, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1);
                queue_cmd(tsbc_pkg::FUNC_LOAD, 4'hF, 16'hFFFF, 16'h0, '0, '0, '0, '0);
                queue_cmd(tsbc_pkg::FUNC_LOAD, 4'd8, 16'h0, 16'hFFFF, '0, '0, '0, '0);
                queue_cmd(tsbc_pkg::FUNC_ENCRYPT, '0, '0, '0, subspace_word(sh),
                          subspace_word(sh), rand_word64(), rand_word64());
            end
            for (int n = 0; n < 70; n++) begin
                sel = $urandom_range(99);
                if (sel < 60)
                    queue_cmd(sel < 30 ? tsbc_pkg::FUNC_ENCRYPT : tsbc_pkg::FUNC_DECRYPT,
                              4'($urandom),
                              16'($urandom), 16'($urandom), subspace_word(sh),
                              subspace_word(sh), rand_word64(), rand_word64());
                else if (sel < 75)
                    queue_cmd(tsbc_pkg::FUNC_LOAD, 4'($urandom_range(NLane - 1)),
                              16'($urandom_range(15)) << sh,
                              16'($urandom_range(15)) << sh,
                              rand_word64(), rand_word64(), rand_word64(), rand_word64());
                else if (sel < 85)
                    queue_cmd(tsbc_pkg::FUNC_LOAD, 4'($urandom_range(NLane - 1)),
                              outside_value(sh),
                              outside_value(sh), rand_word64(), rand_word64(),
                              rand_word64(), rand_word64());
                else if (sel < 95)
                    queue_cmd(tsbc_pkg::FUNC_LOAD, 4'($urandom_range(15, NLane)),
                              16'($urandom),
                              16'($urandom), rand_word64(), rand_word64(),
                              rand_word64(), rand_word64());
                else
                    queue_cmd(tsbc_pkg::FUNC_NONE, 4'($urandom), 16'($urandom),
                              16'($urandom),
                              rand_word64(), rand_word64(), rand_word64(), rand_word64());
            end
        end
        wait_idle();
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #8ms;
        $display("tb: failure");
        $finish;
    end

endmodule
